>>> sv/keyed_quantity_table_core_defines.svh
// Assertion macros for the keyed quantity table RTL.
// No dependencies; included by keyed_quantity_table_core.sv, which carries concurrent checks.
`ifndef KEYED_QUANTITY_TABLE_CORE_DEFINES_SVH
`define KEYED_QUANTITY_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define KQT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keyed quantity table check failed");

// Next-cycle implication, disabled while reset is high.
`define KQT_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keyed quantity table check failed");

`endif

>>> sv/kqt_pkg.sv
// Shared types and constants for the keyed quantity table.
// No dependencies; imported by kqt_store, kqt_ctrl and the top level.
package kqt_pkg;

  localparam int ENTRIES  = 64;
  localparam int IDX_W    = $clog2(ENTRIES);
  localparam int KEY_W    = 16;
  localparam int QTY_W    = 32;
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 3'd0,
    CMD_GET    = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_MODIFY = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [QTY_W-1:0] qty;
  } entry_t;

  // Controller to storage.
  typedef struct packed {
    idx_t   rd_addr;
    idx_t   chk_addr;
    logic   mem_we;
    logic   vld_we;
    logic   vld_val;
    logic   vld_clr_all;
    idx_t   wr_addr;
    entry_t wr_entry;
  } mem_req_t;

  // Storage to controller.
  typedef struct packed {
    entry_t rd_entry;
    logic   chk_valid;
  } mem_rsp_t;

  typedef struct packed {
    logic                found;
    logic [QTY_W-1:0]    qty;
    logic [STATUS_W-1:0] status;
  } result_t;

endpackage

>>> sv/kqt_store.sv
// Entry storage: key/quantity RAM with registered read, plus valid flops.
// Depends on kqt_pkg.
module kqt_store (
  input  logic              clk,
  input  logic              rst,
  input  kqt_pkg::mem_req_t req,
  output kqt_pkg::mem_rsp_t rsp
);
  import kqt_pkg::*;

  entry_t             mem [ENTRIES];
  entry_t             rd_data;
  logic [ENTRIES-1:0] valid;

  always_ff @(posedge clk) begin
    if (req.mem_we) begin
      mem[req.wr_addr] <= req.wr_entry;
    end
    rd_data <= mem[req.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (req.vld_clr_all) begin
      valid <= '0;
    end else if (req.vld_we) begin
      valid[req.wr_addr] <= req.vld_val;
    end
  end

  assign rsp.rd_entry  = rd_data;
  assign rsp.chk_valid = valid[req.chk_addr];

endmodule

>>> sv/kqt_ctrl.sv
// Request sequencer: scans the table for table commands, then executes with at most one table update.
// Depends on kqt_pkg; drives kqt_store through mem_req_t.
module kqt_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [kqt_pkg::CMD_W-1:0]    cmd,
  input  logic [kqt_pkg::KEY_W-1:0]    key,
  input  logic [kqt_pkg::QTY_W-1:0]    quantity_in,
  input  logic                         out_free,
  output logic                         res_load,
  output kqt_pkg::result_t             res,
  output kqt_pkg::mem_req_t            req,
  input  kqt_pkg::mem_rsp_t            rsp
);
  import kqt_pkg::*;

  localparam idx_t LAST = IDX_W'(ENTRIES - 1);

  state_e           state, state_next;
  logic [CMD_W-1:0] cmd_q;
  logic [KEY_W-1:0] key_q;
  logic [QTY_W-1:0] qin_q;
  idx_t             cnt;
  logic             hit;
  idx_t             hit_idx;
  logic [QTY_W-1:0] hit_qty;
  logic             free_seen;
  idx_t             free_idx;

  logic             needs_scan;
  logic             match;
  logic             last;
  logic [QTY_W:0]   sum;
  logic [QTY_W-1:0] sat;

  always_comb begin
    unique case (cmd) inside
      CMD_ADD, CMD_GET, CMD_REMOVE, CMD_MODIFY: needs_scan = 1'b1;
      default:                                  needs_scan = 1'b0;
    endcase
  end

  assign match = rsp.chk_valid && (rsp.rd_entry.key == key_q);
  assign last  = (cnt == LAST);
  assign sum   = {1'b0, hit_qty} + {1'b0, qin_q};
  assign sat   = sum[QTY_W] ? '1 : sum[QTY_W-1:0];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = needs_scan ? S_SCAN : S_EXEC;
        end
      end
      S_SCAN: begin
        if (match || last) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready         = 1'b0;
    res_load         = 1'b0;
    res.found        = 1'b0;
    res.qty          = '0;
    res.status       = ST_OK;
    req.rd_addr      = '0;
    req.chk_addr     = cnt;
    req.mem_we       = 1'b0;
    req.vld_we       = 1'b0;
    req.vld_val      = 1'b0;
    req.vld_clr_all  = 1'b0;
    req.wr_addr      = hit_idx;
    req.wr_entry.key = key_q;
    req.wr_entry.qty = qin_q;
    unique case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        req.rd_addr = '0;
      end
      S_SCAN: begin
        // prefetch the next entry while checking the current one
        req.rd_addr = last ? '0 : cnt + 1'b1;
      end
      S_EXEC: begin
        res_load = out_free;
        unique case (cmd_q) inside
          CMD_ADD: begin
            if (hit) begin
              res.found        = 1'b1;
              res.qty          = sat;
              req.wr_entry.qty = sat;
              req.mem_we       = out_free;
            end else if (free_seen) begin
              res.qty     = qin_q;
              req.wr_addr = free_idx;
              req.mem_we  = out_free;
              req.vld_we  = out_free;
              req.vld_val = 1'b1;
            end else begin
              res.status = ST_FULL;
            end
          end
          CMD_GET: begin
            if (hit) begin
              res.found = 1'b1;
              res.qty   = hit_qty;
            end else begin
              res.status = ST_MISSING;
            end
          end
          CMD_REMOVE: begin
            if (hit) begin
              res.found   = 1'b1;
              req.vld_we  = out_free;
              req.vld_val = 1'b0;
            end else begin
              res.status = ST_MISSING;
            end
          end
          CMD_MODIFY: begin
            if (hit) begin
              res.found  = 1'b1;
              res.qty    = qin_q;
              req.mem_we = out_free;
            end else begin
              res.status = ST_MISSING;
            end
          end
          CMD_CLEAR: begin
            req.vld_clr_all = out_free;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit       <= 1'b0;
      free_seen <= 1'b0;
      cnt       <= '0;
    end else if (state == S_IDLE && in_valid) begin
      hit       <= 1'b0;
      free_seen <= 1'b0;
      cnt       <= '0;
    end else if (state == S_SCAN) begin
      if (match) begin
        hit <= 1'b1;
      end
      if (!rsp.chk_valid && !free_seen) begin
        free_seen <= 1'b1;
      end
      cnt <= cnt + 1'b1;
    end
  end

  // payload captures, no reset
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      cmd_q <= cmd;
      key_q <= key;
      qin_q <= quantity_in;
    end
    if (state == S_SCAN) begin
      if (match) begin
        hit_idx <= cnt;
        hit_qty <= rsp.rd_entry.qty;
      end
      if (!rsp.chk_valid && !free_seen) begin
        free_idx <= cnt;
      end
    end
  end

endmodule

>>> sv/keyed_quantity_table_core.sv
// Keyed quantity table: up to ENTRIES unique 16-bit keys with Q16.16 quantities.
// Clear and unused commands go from idle straight to execute; table commands first scan
//   the slots in order until the matching slot or the last one (one slot per cycle).
// One request in flight: a new request is accepted only after the last result is loaded.
// Reset (synchronous, active high) empties the table at once; no clearing pass.
// Depends on kqt_pkg, kqt_store, kqt_ctrl and keyed_quantity_table_core_defines.svh.
`include "keyed_quantity_table_core_defines.svh"

module keyed_quantity_table_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [kqt_pkg::CMD_W-1:0]       cmd,
  input  logic [kqt_pkg::KEY_W-1:0]       key,
  input  logic [kqt_pkg::QTY_W-1:0]       quantity_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            found,
  output logic [kqt_pkg::QTY_W-1:0]       quantity_out,
  output logic [kqt_pkg::STATUS_W-1:0]    status
);
  import kqt_pkg::*;

  mem_req_t req;
  mem_rsp_t rsp;
  result_t  res;
  logic     res_load;
  logic     out_free;

  // Output register decouples the result from the next request: the
  // sequencer may accept and scan a new request while this one waits.
  assign out_free = !out_valid || out_ready;

  kqt_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .key         (key),
    .quantity_in (quantity_in),
    .out_free    (out_free),
    .res_load    (res_load),
    .res         (res),
    .req         (req),
    .rsp         (rsp)
  );

  // Key/quantity RAM (registered read) and per-slot valid flops.
  kqt_store u_store (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      found        <= res.found;
      quantity_out <= res.qty;
      status       <= res.status;
    end
  end

  // A request keeps the sequencer busy in the cycle after acceptance.
  `KQT_ASSERT_NXT(a_busy_after_req, clk, rst, in_valid && in_ready, !in_ready)
  // The sequencer only hands over a result when the output register is free.
  `KQT_ASSERT_IMP(a_load_when_free, clk, rst, res_load, !out_valid || out_ready)
  // A found key never reports an error status.
  `KQT_ASSERT_IMP(a_found_ok, clk, rst, out_valid && found, status == ST_OK)

endmodule
